// ===== rtl/ibus_frame_parser_scaler_macros.svh =====
// Assertion shorthands shared by the parser and the scaler.
`ifndef IBUS_FRAME_PARSER_SCALER_MACROS_SVH
`define IBUS_FRAME_PARSER_SCALER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IBFPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IBFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ibfps_pkg.sv =====
package ibfps_pkg;

    localparam int NUM_CHANNELS = 14;

    localparam int POS_W    = 5;
    localparam int CH_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [POS_W-1:0] POS_PAY0   = 5'd2;
    localparam logic [POS_W-1:0] POS_CHK_LO = 5'd30;

    localparam logic [7:0] HDR0 = 8'h20;
    localparam logic [7:0] HDR1 = 8'h40;

    localparam logic [16:0] SUM_TARGET = 17'h0FFFF;

    localparam logic [15:0] RAW_LOW  = 16'd1000;
    localparam logic [15:0] RAW_HIGH = 16'd2000;
    localparam logic [9:0]  RAW_SPAN = 10'd1000;

    localparam logic [15:0] OUT_MIN_RST = 16'd0;
    localparam logic [15:0] OUT_MAX_RST = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 2'd1;

    // floor(n / 1000) == (n * RECIP_MULT) >> RECIP_SHIFT for every n below 2^27
    localparam int          RECIP_SHIFT = 37;
    localparam logic [27:0] RECIP_MULT  = 28'd137438954;
    // 1000 * 65535: lifts the signed product to a nonnegative value
    localparam logic [27:0] QUOT_BIAS   = 28'd65535000;

    typedef struct packed {
        logic byte_shift;
        logic word_shift;
    } cell_ctl_t;

endpackage

// ===== rtl/ibfps_cell.sv =====
module ibfps_cell (
    input  logic                 clk,
    input  ibfps_pkg::cell_ctl_t ctl,
    input  logic [7:0]           byte_in,
    input  logic [15:0]          word_in,
    output logic [15:0]          word
);

    logic [7:0] lo_reg;
    logic [7:0] hi_reg;
    logic [7:0] lo_next;
    logic [7:0] hi_next;

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.byte_shift)
        begin
            // advance one byte toward the head of the chain
            lo_next = hi_reg;
            hi_next = byte_in;
        end
        else if (ctl.word_shift)
        begin
            lo_next = word_in[7:0];
            hi_next = word_in[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign word = {hi_reg, lo_reg};

endmodule

// ===== rtl/ibfps_scale.sv =====
`include "ibus_frame_parser_scaler_macros.svh"

module ibfps_scale (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] raw,
    input  logic [15:0] out_min,
    input  logic [15:0] out_max,
    output logic        done,
    output logic [15:0] value
);

    localparam int DEPTH = 6;

    logic [DEPTH-1:0]   vld_reg;
    logic [9:0]         off_reg;
    logic [9:0]         off_next;
    logic signed [16:0] diff_reg;
    logic signed [16:0] diff_next;
    logic signed [27:0] prod_reg;
    logic signed [27:0] prod_next;
    logic [27:0]        biased;
    logic [26:0]        bias_reg;
    logic [40:0]        pl_reg;
    logic [40:0]        pl_next;
    logic [40:0]        ph_reg;
    logic [40:0]        ph_next;
    logic [54:0]        full;
    logic [15:0]        q_reg;
    logic [15:0]        val_reg;

    always_comb
    begin
        priority if (raw < ibfps_pkg::RAW_LOW)
            off_next = '0;
        else if (raw > ibfps_pkg::RAW_HIGH)
            off_next = ibfps_pkg::RAW_SPAN;
        else
            off_next = 10'(raw - ibfps_pkg::RAW_LOW);
        diff_next = $signed({1'b0, out_max}) - $signed({1'b0, out_min});
    end

    assign prod_next = $signed({18'b0, off_reg}) * $signed({{11{diff_reg[16]}}, diff_reg});
    assign biased    = 28'(prod_reg) + ibfps_pkg::QUOT_BIAS;
    assign pl_next   = {14'b0, bias_reg} * {27'b0, ibfps_pkg::RECIP_MULT[13:0]};
    assign ph_next   = {14'b0, bias_reg} * {27'b0, ibfps_pkg::RECIP_MULT[27:14]};
    assign full      = {ph_reg, 14'b0} + {14'b0, pl_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DEPTH-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        off_reg  <= off_next;
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        bias_reg <= biased[26:0];
        pl_reg   <= pl_next;
        ph_reg   <= ph_next;
        q_reg    <= full[ibfps_pkg::RECIP_SHIFT +: 16];
        // drop the bias: quotient - 65535 is quotient + 1 modulo 2^16
        val_reg  <= out_min + q_reg + 16'd1;
    end

    assign done  = vld_reg[DEPTH-1];
    assign value = val_reg;

    `IBFPS_ASSERT_NOW(a_start_idle, clk, rst_n, start, vld_reg == '0,
        "scale started with a word in flight")
    `IBFPS_ASSERT_NOW(a_single_word, clk, rst_n, 1'b1, $onehot0(vld_reg),
        "more than one word in the scaler")
    `IBFPS_ASSERT_NOW(a_done_latency, clk, rst_n, done, $past(start, DEPTH),
        "scale result without matching start")

endmodule

// ===== rtl/ibus_frame_parser_scaler.sv =====
// Receive: one byte per cycle, in_ready high whenever no frame is being emitted.
// After the checksum byte of a good frame, in_ready drops and NUM_CHANNELS words follow;
// each goes from issue to out_valid through the 6-stage scaler, and the next
// channel issues the cycle after the previous one is taken. in_ready returns the cycle
// after the last channel is taken. Bad frames emit nothing and in_ready stays high.
// Reset (rst_n, async): parser hunts for header, out_min = 0, out_max = 1000.
`include "ibus_frame_parser_scaler_macros.svh"

module ibus_frame_parser_scaler #(
    parameter int NUM_CHANNELS = ibfps_pkg::NUM_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ibfps_pkg::CH_W-1:0]        channel_index,
    output logic [15:0]                       channel_value,
    output logic                              last_channel,
    input  logic                              cfg_wr_en,
    input  logic [ibfps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam logic [ibfps_pkg::POS_W-1:0] PAY_KEEP = ibfps_pkg::POS_W'(2 * NUM_CHANNELS);
    localparam logic [ibfps_pkg::CH_W-1:0]  CH_LAST  = ibfps_pkg::CH_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        ST_RECV = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ibfps_pkg::POS_W-1:0]   pos_reg;
    logic [ibfps_pkg::POS_W-1:0]   pos_next;
    logic [ibfps_pkg::POS_W-1:0]   pay_idx;
    logic [15:0]                   sum_reg;
    logic [15:0]                   sum_next;
    logic [7:0]                    chk_lo_reg;
    logic [7:0]                    chk_lo_next;
    logic [ibfps_pkg::CH_W-1:0]    ch_cnt_reg;
    logic [ibfps_pkg::CH_W-1:0]    ch_cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [15:0]                   value_reg;
    logic [15:0]                   out_min_reg;
    logic [15:0]                   out_max_reg;

    logic                          in_acc;
    logic                          out_acc;
    logic                          start;
    logic                          is_last;
    logic [7:0]                    hdr_exp;
    logic                          sum_ok;
    logic                          scale_done;
    logic [15:0]                   scale_value;
    ibfps_pkg::cell_ctl_t          ctl;
    logic [15:0]                   word_w [NUM_CHANNELS];

    assign in_ready = (state_reg == ST_RECV);
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid_reg && out_ready;
    assign start    = (state_reg == ST_EMIT) && !busy_reg;
    assign is_last  = (ch_cnt_reg == CH_LAST);
    assign pay_idx  = pos_reg - ibfps_pkg::POS_PAY0;
    assign hdr_exp  = (pos_reg == '0) ? ibfps_pkg::HDR0 : ibfps_pkg::HDR1;
    assign sum_ok   = ({1'b0, rx_byte, chk_lo_reg} + {1'b0, sum_reg}) == ibfps_pkg::SUM_TARGET;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        chk_lo_next    = chk_lo_reg;
        ch_cnt_next    = ch_cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        ctl.byte_shift = 1'b0;
        ctl.word_shift = start;

        if (in_acc)
        begin
            priority if (pos_reg < ibfps_pkg::POS_PAY0)
            begin
                if (rx_byte == hdr_exp)
                begin
                    sum_next = sum_reg + {8'b0, rx_byte};
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    // restart the hunt; this byte is not retried as a header
                    sum_next = '0;
                    pos_next = '0;
                end
            end
            else if (pos_reg < ibfps_pkg::POS_CHK_LO)
            begin
                ctl.byte_shift = (pay_idx < PAY_KEEP);
                sum_next       = sum_reg + {8'b0, rx_byte};
                pos_next       = pos_reg + 1'b1;
            end
            else if (pos_reg == ibfps_pkg::POS_CHK_LO)
            begin
                chk_lo_next = rx_byte;
                pos_next    = pos_reg + 1'b1;
            end
            else
            begin
                sum_next = '0;
                pos_next = '0;
                if (sum_ok)
                begin
                    state_next  = ST_EMIT;
                    ch_cnt_next = '0;
                end
            end
        end

        if (start)
            busy_next = 1'b1;
        if (scale_done)
            out_valid_next = 1'b1;
        if (out_acc)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
            ch_cnt_next    = ch_cnt_reg + 1'b1;
            if (is_last)
                state_next = ST_RECV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            pos_reg       <= '0;
            sum_reg       <= '0;
            ch_cnt_reg    <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_min_reg   <= ibfps_pkg::OUT_MIN_RST;
            out_max_reg   <= ibfps_pkg::OUT_MAX_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            ch_cnt_reg    <= ch_cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ibfps_pkg::REG_OUT_MIN: out_min_reg <= cfg_data;
                    ibfps_pkg::REG_OUT_MAX: out_max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_lo_reg <= chk_lo_next;
        if (scale_done)
            value_reg <= scale_value;
    end

    // payload chain: bytes enter at the tail, words leave at the head
    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_cell
        logic [7:0]  byte_in;
        logic [15:0] word_in;
        if (i == NUM_CHANNELS - 1)
        begin : g_tail
            assign byte_in = rx_byte;
            assign word_in = '0;
        end
        else
        begin : g_mid
            assign byte_in = word_w[i+1][7:0];
            assign word_in = word_w[i+1];
        end
        ibfps_cell u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .byte_in (byte_in),
            .word_in (word_in),
            .word    (word_w[i])
        );
    end

    ibfps_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .raw     (word_w[0]),
        .out_min (out_min_reg),
        .out_max (out_max_reg),
        .done    (scale_done),
        .value   (scale_value)
    );

    assign out_valid     = out_valid_reg;
    assign channel_index = ch_cnt_reg;
    assign channel_value = value_reg;
    assign last_channel  = is_last;

    `IBFPS_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid_reg, !in_ready,
        "result pending while taking input")
    `IBFPS_ASSERT_NEXT(a_back_to_recv, clk, rst_n, out_acc && is_last, in_ready,
        "parser did not resume after last channel")
    `IBFPS_ASSERT_NOW(a_index_range, clk, rst_n, out_valid_reg, ch_cnt_reg <= CH_LAST,
        "channel index past frame end")

endmodule
